>>> design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clock, reset_n, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clock, reset_n, ante, cons)
`define ASSERT_NEXT(label, clock, reset_n, ante, cons)
`endif
`endif

>>> design/gbs_pkg.sv
// Shared types and constants of the glyph bitmap to span converter.
package gbs_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = 3;
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(BITS_PER_BYTE - 1);

    localparam int DQ_DEPTH = 2;
    localparam int DQ_PTR_W = 1;
    localparam int DQ_CNT_W = 2;

    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = 1;
    localparam int OQ_CNT_W = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GLYPH_WIDTH  = 3'd0,
        REG_GLYPH_HEIGHT = 3'd1,
        REG_X_OFFSET     = 3'd2,
        REG_Y_OFFSET     = 3'd3,
        REG_SCALE        = 3'd4,
        REG_ORIGIN_X     = 3'd5,
        REG_ORIGIN_Y     = 3'd6,
        REG_DRAW_COLOR   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic signed [7:0]  x_offset;
        logic signed [7:0]  y_offset;
        logic [3:0]         scale;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [15:0]        draw_color;
    } cfg_t;

    // One span as found by the scanner, before placement and scaling.
    typedef struct packed {
        logic [8:0] col_end;
        logic [7:0] run;
        logic [7:0] row;
        logic       last;
    } span_desc_t;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [11:0]        width;
        logic [3:0]         height;
        logic [15:0]        color;
        logic               last;
    } span_t;

endpackage

>>> design/gbs_front.sv
// Bit scanner: takes bitmap words, walks their bits and finds foreground runs.
module gbs_front
    import gbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_push,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    output logic       in_full,
    input  logic       q_full,
    output logic       q_push,
    output span_desc_t q_desc
);

    logic [7:0]           byte_reg, byte_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 busy_reg, busy_next;
    logic [7:0]           column_reg, column_next;
    logic [7:0]           row_reg, row_next;
    logic [7:0]           run_reg, run_next;
    logic                 fin_reg, fin_next;
    logic                 pend_valid_reg, pend_valid_next;
    span_desc_t           pend_desc_reg, pend_desc_next;

    logic       bit_val;
    logic       at_end;
    logic       skip;
    logic [7:0] run_inc;
    logic [8:0] col_inc;
    logic [7:0] row_inc;
    logic       row_end;
    logic       emit;
    logic       push_want;
    logic       advance;
    logic       load;
    span_desc_t new_desc;

    always_comb
    begin
        bit_val = byte_reg[7];
        at_end  = (bit_cnt_reg == BIT_LAST);
        skip    = fin_reg || (cfg.glyph_width == 8'd0) || (row_reg >= cfg.glyph_height);
        run_inc = run_reg + 8'd1;
        col_inc = {1'b0, column_reg} + 9'd1;
        row_inc = row_reg + 8'd1;
        row_end = col_inc[8] || (col_inc[7:0] >= cfg.glyph_width);

        // A clear bit closes an open run; a set bit closes it only at the row end.
        emit = busy_reg && !skip &&
               (bit_val ? (row_end && (run_inc != 8'd0)) : (run_reg != 8'd0));

        new_desc.col_end = bit_val ? col_inc : {1'b0, column_reg};
        new_desc.run     = bit_val ? run_inc : run_reg;
        new_desc.row     = row_reg;
        new_desc.last    = at_end;

        // The held span leaves once it is known whether it is the word's last.
        push_want = pend_valid_reg &&
                    (pend_desc_reg.last || (busy_reg && (emit || at_end)));
        advance   = busy_reg && !(push_want && q_full);
        q_push    = push_want && !q_full;
        q_desc      = pend_desc_reg;
        q_desc.last = pend_desc_reg.last || (busy_reg && at_end && !emit);

        in_full = busy_reg && !(advance && at_end);
        load    = in_push && !in_full;

        byte_next       = byte_reg;
        bit_cnt_next    = bit_cnt_reg;
        busy_next       = busy_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        run_next        = run_reg;
        fin_next        = fin_reg;
        pend_valid_next = pend_valid_reg;
        pend_desc_next  = pend_desc_reg;

        if (advance)
        begin
            byte_next    = {byte_reg[6:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
            busy_next    = !at_end;
            if (skip)
            begin
                fin_next = 1'b1;
            end
            else
            begin
                run_next    = bit_val ? run_inc : 8'd0;
                column_next = col_inc[7:0];
                if (row_end)
                begin
                    run_next    = 8'd0;
                    column_next = 8'd0;
                    row_next    = row_inc;
                    if ((row_inc == 8'd0) || (row_inc >= cfg.glyph_height))
                    begin
                        fin_next = 1'b1;
                    end
                end
            end
            if (emit)
            begin
                pend_valid_next = 1'b1;
                pend_desc_next  = new_desc;
            end
            else if (q_push)
            begin
                pend_valid_next = 1'b0;
            end
        end
        else if (q_push)
        begin
            pend_valid_next = 1'b0;
        end

        if (load)
        begin
            byte_next    = in_byte;
            bit_cnt_next = '0;
            busy_next    = 1'b1;
            if (in_start)
            begin
                column_next = 8'd0;
                row_next    = 8'd0;
                run_next    = 8'd0;
                fin_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg    <= '0;
            busy_reg       <= 1'b0;
            column_reg     <= 8'd0;
            row_reg        <= 8'd0;
            run_reg        <= 8'd0;
            fin_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            bit_cnt_reg    <= bit_cnt_next;
            busy_reg       <= busy_next;
            column_reg     <= column_next;
            row_reg        <= row_next;
            run_reg        <= run_next;
            fin_reg        <= fin_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        pend_desc_reg <= pend_desc_next;
    end

endmodule

>>> design/gbs_desc_queue.sv
// Short queue of span descriptors between the scanner and the span builder.
module gbs_desc_queue
    import gbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  span_desc_t din,
    output logic       full,
    input  logic       pop,
    output span_desc_t dout,
    output logic       empty
);

    span_desc_t          mem_reg [DQ_DEPTH];
    logic [DQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [DQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [DQ_CNT_W-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    always_comb
    begin
        full    = (count_reg == DQ_CNT_W'(DQ_DEPTH));
        empty   = (count_reg == '0);
        dout    = mem_reg[rd_ptr_reg];
        do_push = push && !full;
        do_pop  = pop && !empty;

        wr_ptr_next = do_push ? wr_ptr_reg + DQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + DQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + DQ_CNT_W'(do_push) - DQ_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> design/gbs_back.sv
// Span builder: places and scales each span and holds finished spans for the receiver.
module gbs_back
    import gbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_empty,
    input  span_desc_t q_desc,
    output logic       q_pop,
    input  logic       out_pop,
    output logic       out_empty,
    output span_t      out_span
);

    span_t               mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0] count_reg, count_next;
    logic                out_full;
    logic                do_pop;

    logic [3:0]         s_eff;
    logic signed [4:0]  s_sgn;
    logic signed [10:0] x_sum;
    logic signed [9:0]  y_sum;
    logic signed [15:0] x_mul;
    logic signed [14:0] y_mul;
    logic [11:0]        w_mul;
    span_t              span;

    always_comb
    begin
        // A scale of zero draws as a scale of one.
        s_eff = (cfg.scale == 4'd0) ? 4'd1 : cfg.scale;
        s_sgn = $signed({1'b0, s_eff});
        x_sum = 11'(cfg.x_offset) + $signed({2'b00, q_desc.col_end})
                - $signed({3'b000, q_desc.run});
        y_sum = 10'(cfg.y_offset) + $signed({2'b00, q_desc.row});
        x_mul = 16'(x_sum) * 16'(s_sgn);
        y_mul = 15'(y_sum) * 15'(s_sgn);
        w_mul = 12'(q_desc.run) * 12'(s_eff);

        span.x      = 17'(cfg.origin_x) + 17'(x_mul);
        span.y      = 17'(cfg.origin_y) + 17'(y_mul);
        span.width  = w_mul;
        span.height = s_eff;
        span.color  = cfg.draw_color;
        span.last   = q_desc.last;

        out_full  = (count_reg == OQ_CNT_W'(OQ_DEPTH));
        out_empty = (count_reg == '0);
        out_span  = mem_reg[rd_ptr_reg];
        q_pop     = !q_empty && !out_full;
        do_pop    = out_pop && !out_empty;

        wr_ptr_next = q_pop ? wr_ptr_reg + OQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + OQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OQ_CNT_W'(q_pop) - OQ_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mem_reg[wr_ptr_reg] <= span;
        end
    end

endmodule

>>> design/glyph_bitmap_to_spans.sv
// Top level of the glyph bitmap to span converter.
//
// Bitmap words enter through push/full: each word carries eight glyph pixels,
// most significant bit first, and glyph_start marks the first word of a glyph.
// Spans leave through empty/pop as a queue: the oldest span sits on the span
// ports while empty is low, and last_of_item flags the last span of a word.
// A word that closes no run produces no span at all.
// Glyph geometry, placement, scale and colour are set through cfg_wen,
// cfg_index and cfg_data, one register per write, while the block is idle.
// The scanner handles one pixel per cycle while the descriptor queue has room,
// and the next word is accepted in the cycle its last pixel is scanned.
// A span is held in the scanner until the next span or the end of its word
// shows whether it is the word's last; it then passes through the descriptor
// queue and the span builder's output queue before it reaches the span ports.
// When the receiver stops popping, the span queues fill and the scanner waits,
// which in turn raises full. Reset empties all queues and restores the
// register defaults (scale one, colour all ones, everything else zero).
`include "assert_macros.svh"

module glyph_bitmap_to_spans
    import gbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            bitmap_byte,
    input  logic                  glyph_start,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [16:0]    span_x,
    output logic signed [16:0]    span_y,
    output logic [11:0]           span_width,
    output logic [3:0]            span_height,
    output logic [15:0]           span_color,
    output logic                  last_of_item
);

    cfg_t       cfg_reg;
    logic       desc_push;
    logic       desc_full;
    logic       desc_pop;
    logic       desc_empty;
    span_desc_t desc_in;
    span_desc_t desc_out;
    span_t      out_span;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_width  <= 8'd0;
            cfg_reg.glyph_height <= 8'd0;
            cfg_reg.x_offset     <= 8'sd0;
            cfg_reg.y_offset     <= 8'sd0;
            cfg_reg.scale        <= 4'd1;
            cfg_reg.origin_x     <= 16'sd0;
            cfg_reg.origin_y     <= 16'sd0;
            cfg_reg.draw_color   <= 16'hFFFF;
        end
        else if (cfg_wen)
        begin
            case (cfg_index_t'(cfg_index))
                REG_GLYPH_WIDTH:  cfg_reg.glyph_width  <= cfg_data[7:0];
                REG_GLYPH_HEIGHT: cfg_reg.glyph_height <= cfg_data[7:0];
                REG_X_OFFSET:     cfg_reg.x_offset     <= $signed(cfg_data[7:0]);
                REG_Y_OFFSET:     cfg_reg.y_offset     <= $signed(cfg_data[7:0]);
                REG_SCALE:        cfg_reg.scale        <= cfg_data[3:0];
                REG_ORIGIN_X:     cfg_reg.origin_x     <= $signed(cfg_data);
                REG_ORIGIN_Y:     cfg_reg.origin_y     <= $signed(cfg_data);
                REG_DRAW_COLOR:   cfg_reg.draw_color   <= cfg_data;
                default:          cfg_reg.draw_color   <= cfg_reg.draw_color;
            endcase
        end
    end

    gbs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_push  (push),
        .in_byte  (bitmap_byte),
        .in_start (glyph_start),
        .in_full  (full),
        .q_full   (desc_full),
        .q_push   (desc_push),
        .q_desc   (desc_in)
    );

    gbs_desc_queue u_desc_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (desc_push),
        .din   (desc_in),
        .full  (desc_full),
        .pop   (desc_pop),
        .dout  (desc_out),
        .empty (desc_empty)
    );

    gbs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (desc_empty),
        .q_desc    (desc_out),
        .q_pop     (desc_pop),
        .out_pop   (pop),
        .out_empty (empty),
        .out_span  (out_span)
    );

    assign span_x       = out_span.x;
    assign span_y       = out_span.y;
    assign span_width   = out_span.width;
    assign span_height  = out_span.height;
    assign span_color   = out_span.color;
    assign last_of_item = out_span.last;

    // The scanner must wait rather than push into a full descriptor queue.
    `ASSERT_IMPLIES(a_desc_no_overflow, clk, rst_n, desc_push, !desc_full)
    // A waiting span always has a height, since a zero scale draws as one.
    `ASSERT_IMPLIES(a_span_height_set, clk, rst_n, !empty, span_height != 4'd0)
    // A freshly accepted word closes the input as its pixels start to be scanned.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, push && !full, full)

endmodule
